// ===== design/mkla_pkg.sv =====
package mkla_pkg;

    localparam int MAX_KEYS      = 64;
    localparam int KEY_WIDTH     = 32;
    localparam int MAX_TICKETS   = 16;
    localparam int OWNER_ENTRIES = 256;

    localparam int PEND_AW  = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);
    localparam int OWN_AW   = $clog2(OWNER_ENTRIES);
    localparam int USED_W   = $clog2(OWNER_ENTRIES + 1);
    localparam int TK_W     = 4;
    localparam int ACTIVE_W = $clog2(MAX_TICKETS + 1);
    localparam int CAP_W    = 5;

    typedef enum logic [1:0] {
        ACT_ACQUIRE = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_CLOSE   = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_INVALID  = 3'd1,
        ST_CLOSED   = 3'd2,
        ST_CAPACITY = 3'd3,
        ST_BUSY     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DUP_RD,
        S_DUP_CMP,
        S_JUDGE,
        S_BUSY_KEY,
        S_BUSY_RD,
        S_BUSY_CMP,
        S_ALLOC_KEY,
        S_ALLOC_FIND,
        S_REL_RD,
        S_REL_CMP,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]            action;
        logic [KEY_WIDTH-1:0]  lock_key;
        logic                  last_key;
        logic [TK_W-1:0]       release_ticket;
    } in_t;

    typedef struct packed {
        logic [2:0]      status;
        logic [TK_W-1:0] granted_ticket;
        logic            ticket_valid;
        logic            release_ok;
    } out_t;

    typedef struct packed {
        logic    capture;
        logic    pend_push;
        logic    pend_ovf_set;
        logic    pend_clr;
        logic    pend_rd;
        logic    dup_set;
        logic    gate_set;
        logic    i_clr;
        logic    i_inc;
        logic    e_clr;
        logic    e_inc;
        logic    own_rd;
        logic    own_write;
        logic    own_free;
        logic    slot_latch;
        logic    ticket_set;
        logic    ticket_clr;
        logic    out_load;
        status_t out_status;
        logic    out_tv;
        logic    out_rok;
    } cmd_t;

    typedef struct packed {
        logic pend_empty;
        logic pend_full;
        logic i_end;
        logic i_end_dup;
        logic e_end;
        logic key_match_in;
        logic own_valid_e;
        logic own_key_match;
        logic own_tk_match;
        logic rel_hit;
        logic bad_req;
        logic gate_closed;
        logic cap_full;
        logic no_slot;
        logic no_owners;
        logic out_free;
    } stat_t;

endpackage

// ===== design/mkla_ctrl.sv =====
module mkla_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [1:0]      in_action,
    input  logic            in_last,
    input  mkla_pkg::stat_t stat,
    output mkla_pkg::cmd_t  cmd
);

    mkla_pkg::state_t  state_reg, state_next;
    logic              last_reg, last_next;
    mkla_pkg::status_t fin_status_reg, fin_status_next;
    logic              fin_tv_reg, fin_tv_next;
    logic              fin_rok_reg, fin_rok_next;
    logic              fin_acq_reg, fin_acq_next;
    logic              accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mkla_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        last_reg       <= last_next;
        fin_status_reg <= fin_status_next;
        fin_tv_reg     <= fin_tv_next;
        fin_rok_reg    <= fin_rok_next;
        fin_acq_reg    <= fin_acq_next;
    end

    assign s_ready = (state_reg == mkla_pkg::S_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next      = state_reg;
        last_next       = last_reg;
        fin_status_next = fin_status_reg;
        fin_tv_next     = fin_tv_reg;
        fin_rok_next    = fin_rok_reg;
        fin_acq_next    = fin_acq_reg;
        cmd             = '0;
        cmd.out_status  = fin_status_reg;
        cmd.out_tv      = fin_tv_reg;
        cmd.out_rok     = fin_rok_reg;

        unique case (state_reg)
            mkla_pkg::S_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    last_next   = in_last;
                    unique case (mkla_pkg::action_t'(in_action))
                        mkla_pkg::ACT_ACQUIRE: begin
                            fin_acq_next = 1'b1;
                            fin_tv_next  = 1'b0;
                            fin_rok_next = 1'b0;
                            if (stat.pend_full) begin
                                cmd.pend_ovf_set = 1'b1;
                                if (in_last) state_next = mkla_pkg::S_JUDGE;
                            end else begin
                                cmd.pend_push = 1'b1;
                                cmd.i_clr     = 1'b1;
                                if (!stat.pend_empty) begin
                                    state_next = mkla_pkg::S_DUP_RD;
                                end else if (in_last) begin
                                    state_next = mkla_pkg::S_JUDGE;
                                end
                            end
                        end
                        mkla_pkg::ACT_RELEASE: begin
                            fin_acq_next    = 1'b0;
                            fin_tv_next     = 1'b0;
                            fin_status_next = mkla_pkg::ST_ACCEPTED;
                            if (stat.rel_hit) begin
                                cmd.e_clr  = 1'b1;
                                state_next = mkla_pkg::S_REL_RD;
                            end else begin
                                fin_rok_next = 1'b0;
                                state_next   = mkla_pkg::S_FINISH;
                            end
                        end
                        mkla_pkg::ACT_CLOSE: cmd.gate_set = 1'b1;
                        default: ;
                    endcase
                end
            end
            mkla_pkg::S_DUP_RD: begin
                cmd.pend_rd = 1'b1;
                state_next  = mkla_pkg::S_DUP_CMP;
            end
            mkla_pkg::S_DUP_CMP: begin
                cmd.dup_set = stat.key_match_in;
                if (stat.i_end_dup) begin
                    state_next = last_reg ? mkla_pkg::S_JUDGE : mkla_pkg::S_IDLE;
                end else begin
                    cmd.i_inc  = 1'b1;
                    state_next = mkla_pkg::S_DUP_RD;
                end
            end
            mkla_pkg::S_JUDGE: begin
                cmd.slot_latch = 1'b1;
                cmd.i_clr      = 1'b1;
                cmd.e_clr      = 1'b1;
                state_next     = mkla_pkg::S_FINISH;
                priority if (stat.bad_req) begin
                    fin_status_next = mkla_pkg::ST_INVALID;
                end else if (stat.gate_closed) begin
                    fin_status_next = mkla_pkg::ST_CLOSED;
                end else if (stat.cap_full || stat.no_slot || stat.no_owners) begin
                    fin_status_next = mkla_pkg::ST_CAPACITY;
                end else begin
                    state_next = mkla_pkg::S_BUSY_KEY;
                end
            end
            mkla_pkg::S_BUSY_KEY: begin
                cmd.pend_rd = 1'b1;
                state_next  = mkla_pkg::S_BUSY_RD;
            end
            mkla_pkg::S_BUSY_RD: begin
                cmd.own_rd = 1'b1;
                state_next = mkla_pkg::S_BUSY_CMP;
            end
            mkla_pkg::S_BUSY_CMP: begin
                priority if (stat.own_valid_e && stat.own_key_match) begin
                    fin_status_next = mkla_pkg::ST_BUSY;
                    state_next      = mkla_pkg::S_FINISH;
                end else if (stat.e_end) begin
                    cmd.e_clr = 1'b1;
                    if (stat.i_end) begin
                        cmd.i_clr  = 1'b1;
                        state_next = mkla_pkg::S_ALLOC_KEY;
                    end else begin
                        cmd.i_inc  = 1'b1;
                        state_next = mkla_pkg::S_BUSY_KEY;
                    end
                end else begin
                    cmd.e_inc  = 1'b1;
                    state_next = mkla_pkg::S_BUSY_RD;
                end
            end
            mkla_pkg::S_ALLOC_KEY: begin
                cmd.pend_rd = 1'b1;
                state_next  = mkla_pkg::S_ALLOC_FIND;
            end
            mkla_pkg::S_ALLOC_FIND: begin
                if (!stat.own_valid_e) begin
                    cmd.own_write = 1'b1;
                    if (stat.i_end) begin
                        fin_status_next = mkla_pkg::ST_ACCEPTED;
                        fin_tv_next     = 1'b1;
                        state_next      = mkla_pkg::S_FINISH;
                    end else begin
                        cmd.i_inc  = 1'b1;
                        state_next = mkla_pkg::S_ALLOC_KEY;
                    end
                end else begin
                    cmd.e_inc = 1'b1;
                end
            end
            mkla_pkg::S_REL_RD: begin
                cmd.own_rd = 1'b1;
                state_next = mkla_pkg::S_REL_CMP;
            end
            mkla_pkg::S_REL_CMP: begin
                cmd.own_free = stat.own_valid_e && stat.own_tk_match;
                if (stat.e_end) begin
                    cmd.ticket_clr = 1'b1;
                    fin_rok_next   = 1'b1;
                    state_next     = mkla_pkg::S_FINISH;
                end else begin
                    cmd.e_inc  = 1'b1;
                    state_next = mkla_pkg::S_REL_RD;
                end
            end
            mkla_pkg::S_FINISH: begin
                // hold until the output register can take the beat
                if (stat.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.ticket_set = fin_tv_reg;
                    cmd.pend_clr   = fin_acq_reg;
                    state_next     = mkla_pkg::S_IDLE;
                end
            end
            default: state_next = mkla_pkg::S_IDLE;
        endcase
    end

endmodule

// ===== design/mkla_dp.sv =====
module mkla_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  mkla_pkg::in_t                  s_data,
    input  logic [mkla_pkg::CAP_W-1:0]     cap,
    input  mkla_pkg::cmd_t                 cmd,
    output mkla_pkg::stat_t                stat,
    output logic                           m_valid,
    input  logic                           m_ready,
    output mkla_pkg::out_t                 m_data
);

    logic [mkla_pkg::KEY_WIDTH-1:0] pend_mem [mkla_pkg::MAX_KEYS];
    logic [mkla_pkg::KEY_WIDTH-1:0] own_key_mem [mkla_pkg::OWNER_ENTRIES];
    logic [mkla_pkg::TK_W-1:0]      own_tk_mem [mkla_pkg::OWNER_ENTRIES];

    logic [mkla_pkg::CNT_W-1:0]         cnt_reg;
    logic                               ovf_reg, zero_reg, dup_reg;
    logic [mkla_pkg::PEND_AW-1:0]       i_reg;
    logic [mkla_pkg::OWN_AW-1:0]        e_reg;
    logic [mkla_pkg::KEY_WIDTH-1:0]     pk_q, ok_q, in_key_reg;
    logic [mkla_pkg::TK_W-1:0]          ot_q, in_ticket_reg, slot_reg;
    logic [mkla_pkg::OWNER_ENTRIES-1:0] own_valid_reg;
    logic [mkla_pkg::USED_W-1:0]        used_reg;
    logic [mkla_pkg::MAX_TICKETS-1:0]   active_reg;
    logic                               gate_reg;
    logic                               m_valid_reg;
    mkla_pkg::out_t                     m_data_reg;

    logic [mkla_pkg::ACTIVE_W-1:0] active_cnt;
    logic [mkla_pkg::TK_W-1:0]     free_slot;
    logic [mkla_pkg::CNT_W-1:0]    i_ext;
    logic [mkla_pkg::USED_W-1:0]   free_owners;

    always_comb begin
        active_cnt = '0;
        free_slot  = '0;
        for (int s = mkla_pkg::MAX_TICKETS - 1; s >= 0; s--) begin
            active_cnt = active_cnt + mkla_pkg::ACTIVE_W'(active_reg[s]);
            if (!active_reg[s]) free_slot = mkla_pkg::TK_W'(s);
        end
    end

    assign i_ext       = mkla_pkg::CNT_W'(i_reg);
    assign free_owners = mkla_pkg::USED_W'(mkla_pkg::OWNER_ENTRIES) - used_reg;

    assign stat.pend_empty    = (cnt_reg == '0);
    assign stat.pend_full     = (cnt_reg == mkla_pkg::CNT_W'(mkla_pkg::MAX_KEYS));
    assign stat.i_end         = (i_ext + mkla_pkg::CNT_W'(1) == cnt_reg);
    assign stat.i_end_dup     = (i_ext + mkla_pkg::CNT_W'(2) == cnt_reg);
    assign stat.e_end         = (e_reg == mkla_pkg::OWN_AW'(mkla_pkg::OWNER_ENTRIES - 1));
    assign stat.key_match_in  = (pk_q == in_key_reg);
    assign stat.own_valid_e   = own_valid_reg[e_reg];
    assign stat.own_key_match = (ok_q == pk_q);
    assign stat.own_tk_match  = (ot_q == in_ticket_reg);
    assign stat.rel_hit       = active_reg[s_data.release_ticket];
    assign stat.bad_req       = ovf_reg || zero_reg || dup_reg || (cnt_reg == '0);
    assign stat.gate_closed   = gate_reg;
    assign stat.cap_full      = (mkla_pkg::CAP_W'(active_cnt) >= cap);
    assign stat.no_slot       = &active_reg;
    assign stat.no_owners     = (free_owners < mkla_pkg::USED_W'(cnt_reg));
    assign stat.out_free      = !m_valid_reg || m_ready;

    // stores and registered read data
    always_ff @(posedge aclk) begin
        if (cmd.pend_push) pend_mem[cnt_reg[mkla_pkg::PEND_AW-1:0]] <= s_data.lock_key;
        if (cmd.pend_rd) pk_q <= pend_mem[i_reg];
        if (cmd.own_write) begin
            own_key_mem[e_reg] <= pk_q;
            own_tk_mem[e_reg]  <= slot_reg;
        end
        if (cmd.own_rd) begin
            ok_q <= own_key_mem[e_reg];
            ot_q <= own_tk_mem[e_reg];
        end
        if (cmd.capture) begin
            in_key_reg    <= s_data.lock_key;
            in_ticket_reg <= s_data.release_ticket;
        end
        if (cmd.slot_latch) slot_reg <= free_slot;
        if (cmd.out_load) begin
            m_data_reg.status         <= cmd.out_status;
            m_data_reg.granted_ticket <= cmd.out_tv ? slot_reg : '0;
            m_data_reg.ticket_valid   <= cmd.out_tv;
            m_data_reg.release_ok     <= cmd.out_rok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            zero_reg      <= 1'b0;
            dup_reg       <= 1'b0;
            i_reg         <= '0;
            e_reg         <= '0;
            own_valid_reg <= '0;
            used_reg      <= '0;
            active_reg    <= '0;
            gate_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.pend_clr) begin
                cnt_reg  <= '0;
                ovf_reg  <= 1'b0;
                zero_reg <= 1'b0;
                dup_reg  <= 1'b0;
            end else begin
                if (cmd.pend_push) begin
                    cnt_reg <= cnt_reg + mkla_pkg::CNT_W'(1);
                    if (s_data.lock_key == '0) zero_reg <= 1'b1;
                end
                if (cmd.pend_ovf_set) ovf_reg <= 1'b1;
                if (cmd.dup_set) dup_reg <= 1'b1;
            end
            if (cmd.i_clr) i_reg <= '0;
            else if (cmd.i_inc) i_reg <= i_reg + mkla_pkg::PEND_AW'(1);
            if (cmd.e_clr) e_reg <= '0;
            else if (cmd.e_inc) e_reg <= e_reg + mkla_pkg::OWN_AW'(1);
            if (cmd.own_write) begin
                own_valid_reg[e_reg] <= 1'b1;
                used_reg             <= used_reg + mkla_pkg::USED_W'(1);
            end else if (cmd.own_free) begin
                own_valid_reg[e_reg] <= 1'b0;
                used_reg             <= used_reg - mkla_pkg::USED_W'(1);
            end
            if (cmd.ticket_set) active_reg[slot_reg] <= 1'b1;
            if (cmd.ticket_clr) active_reg[in_ticket_reg] <= 1'b0;
            if (cmd.gate_set) gate_reg <= 1'b1;
            if (cmd.out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/multi_key_lock_admission.sv =====
// Admission gate for multi-key lock requests. Stream an acquire's keys as
// action 0 beats and mark the final key with last_key; a result beat comes
// back on each final key and on each release, none for other beats. A
// non-final key is compared against the keys already in the pending-key
// store one entry at a time to flag duplicates. A final key adds the judge,
// then, when it gets as far as the ownership check, compares each key
// against every owner entry through the single read port of the owner
// store, then allocation walks the owner store once more. A release of an
// active ticket scans all 256 owner entries. The result sits in an output
// register, so the next beat is taken while it waits. Write ticket_capacity
// only while idle.
module multi_key_lock_admission (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  mkla_pkg::in_t              s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output mkla_pkg::out_t             m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [1:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    mkla_pkg::cmd_t             cmd;
    mkla_pkg::stat_t            stat;
    logic [mkla_pkg::CAP_W-1:0] cap_reg;

    assign pready = 1'b1;
    assign prdata = {{(32 - mkla_pkg::CAP_W){1'b0}}, cap_reg};

    // single register: every address decodes to ticket_capacity
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= mkla_pkg::CAP_W'(mkla_pkg::MAX_TICKETS);
        end else if (psel && penable && pwrite && pready) begin
            cap_reg <= pwdata[mkla_pkg::CAP_W-1:0] | {mkla_pkg::CAP_W{paddr[0] & 1'b0}};
        end
    end

    mkla_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .in_action (s_data.action),
        .in_last   (s_data.last_key),
        .stat      (stat),
        .cmd       (cmd)
    );

    mkla_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cap     (cap_reg),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_tv_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.ticket_valid |-> m_data.status == mkla_pkg::ST_ACCEPTED)
        else $error("granted ticket without accepted status");

    a_tv_rok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.ticket_valid && m_data.release_ok))
        else $error("grant and release flagged in one beat");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !m_valid || m_ready)
        else $error("result overwrote an untaken beat");

endmodule

// ===== test/multi_key_lock_admission_tb.sv =====
`timescale 1ns / 1ps

module multi_key_lock_admission_tb;

    class lock_scoreboard;
        logic [31:0]    pend_keys[64];
        int             pend_cnt;
        bit             pend_ovf;
        logic [31:0]    own_key[256];
        logic [3:0]     own_tk[256];
        bit             own_vld[256];
        bit             tk_active[16];
        bit             gate_shut;
        int             cap_limit;
        mkla_pkg::out_t expected_q[$];
        int             errors;

        function new();
            pend_cnt = 0;
            pend_ovf = 0;
            gate_shut = 0;
            cap_limit = 16;
            errors = 0;
            foreach (own_vld[e]) own_vld[e] = 0;
            foreach (tk_active[s]) tk_active[s] = 0;
        endfunction

        function mkla_pkg::status_t judge(output logic [3:0] slot);
            int active, free_own, s, j;
            bit owned;
            active = 0;
            free_own = 0;
            slot = 0;
            if (pend_ovf || pend_cnt == 0) return mkla_pkg::ST_INVALID;
            for (int i = 0; i < pend_cnt; i++) begin
                if (pend_keys[i] == 0) return mkla_pkg::ST_INVALID;
                for (j = 0; j < i; j++)
                    if (pend_keys[j] == pend_keys[i]) return mkla_pkg::ST_INVALID;
            end
            if (gate_shut) return mkla_pkg::ST_CLOSED;
            foreach (tk_active[t]) if (tk_active[t]) active++;
            if (active >= cap_limit) return mkla_pkg::ST_CAPACITY;
            for (s = 0; s < 16 && tk_active[s]; s++) ;
            if (s >= 16) return mkla_pkg::ST_CAPACITY;
            foreach (own_vld[e]) if (!own_vld[e]) free_own++;
            if (free_own < pend_cnt) return mkla_pkg::ST_CAPACITY;
            for (int i = 0; i < pend_cnt; i++) begin
                owned = 0;
                foreach (own_vld[e]) if (own_vld[e] && own_key[e] == pend_keys[i]) owned = 1;
                if (owned) return mkla_pkg::ST_BUSY;
            end
            tk_active[s] = 1;
            j = 0;
            for (int i = 0; i < pend_cnt; i++) begin
                while (j < 256 && own_vld[j]) j++;
                own_vld[j] = 1;
                own_key[j] = pend_keys[i];
                own_tk[j] = s[3:0];
            end
            slot = s[3:0];
            return mkla_pkg::ST_ACCEPTED;
        endfunction

        function void note_input(mkla_pkg::in_t b);
            mkla_pkg::out_t    r;
            mkla_pkg::status_t st;
            logic [3:0]        slot;
            r = '0;
            case (mkla_pkg::action_t'(b.action))
                mkla_pkg::ACT_ACQUIRE: begin
                    if (pend_cnt < 64) pend_keys[pend_cnt++] = b.lock_key;
                    else pend_ovf = 1;
                    if (b.last_key) begin
                        st = judge(slot);
                        pend_cnt = 0;
                        pend_ovf = 0;
                        r.status = st;
                        r.granted_ticket = (st == mkla_pkg::ST_ACCEPTED) ? slot : 4'd0;
                        r.ticket_valid = (st == mkla_pkg::ST_ACCEPTED);
                        expected_q.push_back(r);
                    end
                end
                mkla_pkg::ACT_RELEASE: begin
                    if (tk_active[b.release_ticket]) begin
                        r.release_ok = 1;
                        foreach (own_vld[e])
                            if (own_vld[e] && own_tk[e] == b.release_ticket) own_vld[e] = 0;
                        tk_active[b.release_ticket] = 0;
                    end
                    r.status = mkla_pkg::ST_ACCEPTED;
                    expected_q.push_back(r);
                end
                mkla_pkg::ACT_CLOSE: gate_shut = 1;
                default: ;
            endcase
        endfunction

        function void check_result(mkla_pkg::out_t got);
            mkla_pkg::out_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.granted_ticket !== want.granted_ticket ||
                got.ticket_valid !== want.ticket_valid || got.release_ok !== want.release_ok) begin
                $display({"%0t: mismatch expected st=%0d tk=%0d tv=%0b rok=%0b",
                          " got st=%0d tk=%0d tv=%0b rok=%0b"},
                         $time, want.status, want.granted_ticket, want.ticket_valid,
                         want.release_ok, got.status, got.granted_ticket, got.ticket_valid,
                         got.release_ok);
                errors++;
            end
        endfunction
    endclass

    logic           aclk = 0;
    logic           aresetn = 0;
    logic           s_valid = 0;
    logic           s_ready;
    mkla_pkg::in_t  s_data = '0;
    logic           m_valid;
    logic           m_ready = 0;
    mkla_pkg::out_t m_data;
    logic           psel = 0;
    logic           penable = 0;
    logic           pwrite = 0;
    logic [1:0]     paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;

    lock_scoreboard sb = new();
    int sender_idle = 0;
    int recv_idle = 0;

    multi_key_lock_admission uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    always @(negedge aclk) m_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge aclk)
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // valid stays high into the next beat unless the sender idles
    task automatic beat(mkla_pkg::action_t a, logic [31:0] k, logic l, logic [3:0] t);
        mkla_pkg::in_t b;
        b.action = a;
        b.lock_key = k;
        b.last_key = l;
        b.release_ticket = t;
        if ($urandom_range(99) < sender_idle) begin
            @(negedge aclk) s_valid <= 0;
            repeat ($urandom_range(3)) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1;
        s_data <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(b);
    endtask

    task automatic acquire(logic [31:0] ks[$]);
        foreach (ks[i])
            beat(mkla_pkg::ACT_ACQUIRE, ks[i], i == ks.size() - 1, 4'($urandom));
    endtask

    // hold until every result is back, then let a trailing scan finish
    task automatic drain();
        @(negedge aclk) s_valid <= 0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    task automatic write_capacity(int value);
        @(negedge aclk);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= 2'd0; pwdata <= value;
        @(negedge aclk) penable <= 1;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.cap_limit = value & 31;
        @(negedge aclk);
        psel <= 1; penable <= 0;
        @(negedge aclk) penable <= 1;
        @(posedge aclk);
        if (prdata[4:0] !== 5'(value)) begin
            $display("%0t: capacity readback expected %0d got %0d", $time, value & 31, prdata);
            sb.errors++;
        end
        @(negedge aclk);
        psel <= 0; penable <= 0;
    endtask

    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 4) return 0;
        if (r < 25) return $urandom;
        return $urandom_range(40, 1);
    endfunction

    task automatic random_phase(int beats, bit with_close);
        logic [31:0] ks[$];
        int n, sent, r;
        sent = 0;
        while (sent < beats) begin
            r = $urandom_range(99);
            if (with_close && sent > beats / 2 && !sb.gate_shut && r < 3) begin
                beat(mkla_pkg::ACT_CLOSE, $urandom, 1'($urandom), 4'($urandom));
                sent++;
            end else if (r < 58) begin
                ks.delete();
                n = $urandom_range(5, 1);
                for (int i = 0; i < n; i++) ks.push_back(pick_key());
                foreach (ks[i]) begin
                    // drop a release into the middle of a request now and then
                    if ($urandom_range(99) < 5)
                        beat(mkla_pkg::ACT_RELEASE, $urandom, 1'($urandom), 4'($urandom));
                    beat(mkla_pkg::ACT_ACQUIRE, ks[i], i == n - 1, 4'($urandom));
                end
                sent += n;
            end else if (r < 95) begin
                beat(mkla_pkg::ACT_RELEASE, $urandom, 1'($urandom), 4'($urandom));
                sent++;
            end else begin
                beat(mkla_pkg::ACT_NONE, $urandom, 1'($urandom), 4'($urandom));
            end
        end
    endtask

    initial begin
        logic [31:0] ks[$];
        repeat (10) @(posedge aclk);
        @(negedge aclk) aresetn <= 1;
        write_capacity(16);

        acquire('{32'hFFFF_FFFF});
        acquire('{32'h0});
        acquire('{32'd5, 32'd5});
        acquire('{32'd7, 32'hFFFF_FFFF});
        beat(mkla_pkg::ACT_ACQUIRE, 32'h8000_0000, 0, 4'hF);
        beat(mkla_pkg::ACT_RELEASE, 32'h0, 1, 4'd15);
        beat(mkla_pkg::ACT_ACQUIRE, 32'h1, 1, 4'h0);
        beat(mkla_pkg::ACT_RELEASE, 32'h0, 0, 4'd0);
        beat(mkla_pkg::ACT_RELEASE, 32'h0, 0, 4'd0);
        beat(mkla_pkg::ACT_NONE, 32'hFFFF_FFFF, 1, 4'hF);
        beat(mkla_pkg::ACT_RELEASE, 32'h0, 0, 4'd1);
        ks.delete();
        for (int i = 0; i < 65; i++) ks.push_back(i + 1);
        acquire(ks);
        // fill the owner store exactly, then one more key must bounce
        for (int t = 0; t < 4; t++) begin
            ks.delete();
            for (int i = 0; i < 64; i++) ks.push_back(t * 64 + i + 1);
            acquire(ks);
        end
        acquire('{32'd1000});
        for (int t = 0; t < 4; t++) beat(mkla_pkg::ACT_RELEASE, 32'h0, 0, 4'(t));
        drain();

        write_capacity(0);
        acquire('{32'd9});
        drain();
        write_capacity(31);
        for (int t = 0; t < 17; t++) acquire('{32'(100 + t)});
        for (int t = 0; t < 16; t++) beat(mkla_pkg::ACT_RELEASE, 32'h0, 0, 4'(t));
        drain();

        sender_idle = 31; recv_idle = 55;
        write_capacity(3);
        random_phase(20, 0);
        drain();
        sender_idle = 55; recv_idle = 31;
        write_capacity(16);
        random_phase(20, 0);
        drain();
        sender_idle = 0; recv_idle = 0;
        write_capacity(8);
        random_phase(30, 1);
        drain();

        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
